@@ hw/rtl/pimap_pkg.sv @@
`default_nettype none
package pimap_pkg;

    // register slots on the configuration port, word index
    typedef enum logic [2:0] {
        REG_MASK_HI     = 3'd0,
        REG_MASK_MID    = 3'd1,
        REG_MASK_LO     = 3'd2,
        REG_MASK_PIN    = 3'd3,
        REG_GIC_HANDLE  = 3'd4,
        REG_MAP_ENABLE  = 3'd5,
        REG_ENTRY_COUNT = 3'd6
    } t_reg;

    // request operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // interrupt decode limits
    localparam logic [31:0] IRQ_TYPE_SPI = 32'd0;
    localparam logic [31:0] IRQ_TYPE_PPI = 32'd1;
    localparam logic [31:0] SPI_LIMIT    = 32'd988;
    localparam logic [31:0] SPI_BASE     = 32'd32;
    localparam logic [31:0] PPI_LIMIT    = 32'd16;
    localparam logic [31:0] PPI_BASE     = 32'd16;

    // pci address limits
    localparam logic [7:0]  DEV_LIMIT    = 8'd32;
    localparam logic [7:0]  FN_LIMIT     = 8'd8;
    localparam logic [31:0] PIN_MIN      = 32'd1;
    localparam logic [31:0] PIN_MAX      = 32'd4;

    // one stored map entry
    typedef struct packed {
        logic [31:0] unit_hi;
        logic [31:0] unit_mid;
        logic [31:0] unit_lo;
        logic [31:0] pin;
        logic [31:0] parent;
        logic [9:0]  irq;
    } t_entry;

    // what the back end has to do with a request
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_SKIP   = 2'd2
    } t_cmd_kind;

    // classified request; on lookup entry.unit_hi holds the pci address
    // and entry.pin the requested pin
    typedef struct packed {
        t_cmd_kind   kind;
        logic [5:0]  index;
        t_entry      entry;
    } t_cmd;

    // configuration register bank
    typedef struct packed {
        logic [31:0] mask_hi;
        logic [31:0] mask_mid;
        logic [31:0] mask_lo;
        logic [31:0] mask_pin;
        logic [31:0] gic_handle;
        logic        map_enable;
        logic [6:0]  entry_count;
    } t_cfg;

    // parent interrupt cells to controller interrupt number
    function automatic logic [9:0] decode_irq(input logic [31:0] irq_type,
                                              input logic [31:0] irq_number);
        logic [9:0] result;
        result = '0;
        if (irq_type == IRQ_TYPE_SPI && irq_number < SPI_LIMIT) begin
            result = 10'(irq_number + SPI_BASE);
        end else if (irq_type == IRQ_TYPE_PPI && irq_number < PPI_LIMIT) begin
            result = 10'(irq_number + PPI_BASE);
        end
        return result;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pimap_front.sv @@
`default_nettype none
module pimap_front
    import pimap_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = 64
) (
    input  wire logic        i_op,
    input  wire logic [5:0]  i_entry_index,
    input  wire logic [31:0] i_unit_hi,
    input  wire logic [31:0] i_unit_mid,
    input  wire logic [31:0] i_unit_lo,
    input  wire logic [31:0] i_pin,
    input  wire logic [31:0] i_parent_handle,
    input  wire logic [31:0] i_irq_type,
    input  wire logic [31:0] i_irq_number,
    input  wire logic [7:0]  i_bus,
    input  wire logic [7:0]  i_device,
    input  wire logic [7:0]  i_function_req,
    input  wire t_cfg        i_cfg,
    output t_cmd             o_cmd
);

    logic        slot_ok;
    logic        lookup_ok;
    logic [31:0] pci_addr;

    // write slot inside the table
    assign slot_ok = 11'(i_entry_index) < 11'(MAP_ENTRIES);

    // lookup admission checks
    assign lookup_ok = i_cfg.map_enable && (i_cfg.gic_handle != '0)
                    && (i_device < DEV_LIMIT) && (i_function_req < FN_LIMIT)
                    && (i_pin >= PIN_MIN) && (i_pin <= PIN_MAX);

    // bus << 16 | device << 11 | function << 8
    assign pci_addr = {8'd0, i_bus, i_device[4:0], i_function_req[2:0], 8'd0};

    // classify the request
    always_comb begin
        o_cmd.index          = i_entry_index;
        o_cmd.entry.unit_mid = i_unit_mid;
        o_cmd.entry.unit_lo  = i_unit_lo;
        o_cmd.entry.pin      = i_pin;
        o_cmd.entry.parent   = i_parent_handle;
        o_cmd.entry.irq      = decode_irq(i_irq_type, i_irq_number);
        if (i_op == OP_WRITE) begin
            o_cmd.kind          = slot_ok ? CMD_WRITE : CMD_SKIP;
            o_cmd.entry.unit_hi = i_unit_hi;
        end else begin
            o_cmd.kind          = lookup_ok ? CMD_LOOKUP : CMD_SKIP;
            o_cmd.entry.unit_hi = pci_addr;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pimap_queue.sv @@
`default_nettype none
module pimap_queue
    import pimap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_data
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // two-entry command fifo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pimap_back.sv @@
`default_nettype none
module pimap_back
    import pimap_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [9:0]       o_out_irq,
    output logic             o_out_found
);

    localparam int unsigned AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAP_ENTRIES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state          r_state;
    t_entry          r_mem [MAP_ENTRIES];
    t_entry          r_rd_data;
    t_cmd            r_cmd;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_limit;
    logic            r_chk;
    logic            r_out_valid;
    logic [9:0]      r_out_irq;
    logic            r_out_found;

    logic            out_free;
    logic            out_load;
    logic            hit;
    logic            done;
    logic            stall;
    logic            rd_en;
    logic            wr_en;
    logic [10:0]     count_ext;
    logic [CW-1:0]   n_limit;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid && out_free;
    assign wr_en     = o_cmd_pop && (i_cmd.kind == CMD_WRITE);

    // scan length clipped to the table depth
    assign count_ext = 11'(i_cfg.entry_count);
    assign n_limit   = (count_ext > 11'(MAP_ENTRIES)) ? CW'(MAP_ENTRIES) : CW'(count_ext);

    // entry compare against the lookup request
    assign hit = r_chk
              && ((r_rd_data.unit_hi & i_cfg.mask_hi) == (r_cmd.entry.unit_hi & i_cfg.mask_hi))
              && ((r_rd_data.unit_mid & i_cfg.mask_mid) == '0)
              && ((r_rd_data.unit_lo & i_cfg.mask_lo) == '0)
              && ((r_rd_data.pin & i_cfg.mask_pin) == (r_cmd.entry.pin & i_cfg.mask_pin))
              && (r_rd_data.parent == i_cfg.gic_handle);

    assign done  = hit || (!r_chk && (r_idx >= r_limit));
    assign stall = done && !out_free;
    assign rd_en = (r_state == ST_SCAN) && !done && (r_idx < r_limit);

    // a result enters the output register this cycle
    assign out_load = ((r_state == ST_IDLE) && o_cmd_pop && (i_cmd.kind != CMD_LOOKUP))
                   || ((r_state == ST_SCAN) && done && out_free);

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_cmd.index)] <= i_cmd.entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chk       <= 1'b0;
            r_idx       <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
            r_out_irq   <= '0;
            r_out_found <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.kind == CMD_LOOKUP) begin
                            r_state <= ST_SCAN;
                            r_cmd   <= i_cmd;
                            r_idx   <= '0;
                            r_limit <= n_limit;
                            r_chk   <= 1'b0;
                        end else begin
                            r_out_irq   <= '0;
                            r_out_found <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        r_chk <= rd_en;
                        if (rd_en) begin
                            r_idx <= r_idx + CW'(1);
                        end
                        if (done) begin
                            r_state     <= ST_IDLE;
                            r_out_irq   <= hit ? r_rd_data.irq : '0;
                            r_out_found <= hit;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_irq   = r_out_irq;
    assign o_out_found = r_out_found;

endmodule
`default_nettype wire

@@ hw/rtl/pci_interrupt_map_lookup_unit.sv @@
// channel   direction  signals                         request
// s_axis    in         tvalid tready tdata tuser       table write or interrupt lookup
// m_axis    out        tvalid tready tdata tuser       interrupt number and match flag
// apb       in         psel penable pwrite paddr ...   register write / read
//
// a table write or a refused lookup leaves the back end in the cycle after it is dequeued
// a lookup makes one table read per cycle on the single
// read port of the entry memory, stopping at the first match
// a two-entry request fifo lets the input side run ahead while a scan is busy
// reset clears control and registers only; table entries hold garbage until written
`default_nettype none
module pci_interrupt_map_lookup_unit
    import pimap_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_index[5:0] unit_hi[37:6] unit_mid[69:38] unit_lo[101:70] pin[133:102]
    // parent_handle[165:134] irq_type[197:166] irq_number[229:198] bus[237:230]
    // device[245:238] function_req[253:246], zero pad[255:254]
    input  wire logic [255:0] s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // irq[9:0], zero pad[15:10]
    output logic [15:0]       m_axis_tdata,
    // found[0]
    output logic [0:0]        m_axis_tuser
);

    t_cfg       r_cfg;
    t_reg       reg_sel;
    logic       cfg_wr;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic [9:0] out_irq;
    logic       out_found;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MASK_HI:     r_cfg.mask_hi     <= pwdata;
                REG_MASK_MID:    r_cfg.mask_mid    <= pwdata;
                REG_MASK_LO:     r_cfg.mask_lo     <= pwdata;
                REG_MASK_PIN:    r_cfg.mask_pin    <= pwdata;
                REG_GIC_HANDLE:  r_cfg.gic_handle  <= pwdata;
                REG_MAP_ENABLE:  r_cfg.map_enable  <= pwdata[0];
                REG_ENTRY_COUNT: r_cfg.entry_count <= pwdata[6:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // configuration register reads
    always_comb begin
        case (reg_sel)
            REG_MASK_HI:     prdata = r_cfg.mask_hi;
            REG_MASK_MID:    prdata = r_cfg.mask_mid;
            REG_MASK_LO:     prdata = r_cfg.mask_lo;
            REG_MASK_PIN:    prdata = r_cfg.mask_pin;
            REG_GIC_HANDLE:  prdata = r_cfg.gic_handle;
            REG_MAP_ENABLE:  prdata = 32'(r_cfg.map_enable);
            REG_ENTRY_COUNT: prdata = 32'(r_cfg.entry_count);
            default:         prdata = '0;
        endcase
    end

    // request classification
    pimap_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .i_op            (s_axis_tuser[0]),
        .i_entry_index   (s_axis_tdata[5:0]),
        .i_unit_hi       (s_axis_tdata[37:6]),
        .i_unit_mid      (s_axis_tdata[69:38]),
        .i_unit_lo       (s_axis_tdata[101:70]),
        .i_pin           (s_axis_tdata[133:102]),
        .i_parent_handle (s_axis_tdata[165:134]),
        .i_irq_type      (s_axis_tdata[197:166]),
        .i_irq_number    (s_axis_tdata[229:198]),
        .i_bus           (s_axis_tdata[237:230]),
        .i_device        (s_axis_tdata[245:238]),
        .i_function_req  (s_axis_tdata[253:246]),
        .i_cfg           (r_cfg),
        .o_cmd           (front_cmd)
    );

    assign s_axis_tready = !q_full;

    // decoupling fifo
    pimap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    // table storage and scan
    pimap_back #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_irq   (out_irq),
        .o_out_found (out_found)
    );

    assign m_axis_tdata = {6'd0, out_irq};
    assign m_axis_tuser = out_found;

endmodule
`default_nettype wire
